// ===== design/sfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpa_pkg
// Shared constants, command types and helpers for the sensor frame parser
// and block averager.
// ----------------------------------------------------------------------------
package sfpa_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned SUM_W       = 32;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned STATUS_W    = 24;
   localparam int unsigned PRESS_W     = 24;
   localparam int unsigned TEMP_W      = 16;
   localparam int unsigned SHIFT_W     = 3;
   localparam int unsigned POS_W       = 4;
   localparam int unsigned CSR_IDX_W   = 2;

   // frame layout
   localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
   localparam logic [POS_W-1:0] POS_CRC_LAST = 4'd10;
   localparam logic [POS_W-1:0] POS_CRC_LO   = 4'd11;
   localparam logic [POS_W-1:0] POS_CRC_HI   = 4'd12;

   // crc
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam int unsigned CRC_CNT_W = 3;

   // divider: one quotient bit per cycle
   localparam int unsigned DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

   // clamp limits
   localparam logic [SUM_W-1:0] PRESS_MAX = 32'h007F_FFFF;
   localparam logic [SUM_W-1:0] TEMP_MAX  = 32'h0000_7FFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SHIFT = 2'd2;

   localparam logic [BYTE_W-1:0]  START_RESET = 8'h35;
   localparam logic [BYTE_W-1:0]  FULL_RESET  = 8'd8;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;

   typedef struct packed {
      logic              start;
      logic              clear;
      logic [BYTE_W-1:0] data;
   } crc_cmd_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [BYTE_W-1:0] divisor;
   } div_cmd_type;

   // signed clamp of a sign/magnitude value to [-(limit+1), limit]
   function automatic logic [SUM_W-1:0] clamp_mag(input logic neg,
                                                  input logic [SUM_W-1:0] mag,
                                                  input logic [SUM_W-1:0] limit);
      logic [SUM_W-1:0] r;
      if (!neg) begin
         r = (mag > limit) ? limit : mag;
      end else begin
         r = (mag > limit + 32'd1) ? ~limit : (~mag + 32'd1);
      end
      return r;
   endfunction

   function automatic logic [SUM_W-1:0] magnitude(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] r;
      r = v[SUM_W-1] ? (~v + 32'd1) : v;
      return r;
   endfunction

endpackage

// ===== design/sensor_frame_parser_averager_core.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_parser_averager_core
// Hunts for frames in a byte stream, checks their CRC-16, accumulates the
// pressure, temperature and status of good frames and reports block
// averages and running totals on each block end.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  rx_byte, block_end
//   rsp_      out        rsp_valid/rsp_ready  averages, status, counts
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// A byte fed through the bit-serial CRC (frame bytes 0 to 10) waits in ST_CRC
// for the eight CRC steps to finish before the next byte is taken.
// A block end runs the averaging states; when the count is neither zero nor
// the full count, the serial divider is run for each average.
// Reset is synchronous; csr_ready is always high.
// A result waits in the output register; the next block end holds there
// until rsp_ready takes it.
// ----------------------------------------------------------------------------
module sensor_frame_parser_averager_core (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_rx_byte,
   input  logic                                  req_block_end,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [23:0]                    rsp_pressure_avg,
   output logic signed [15:0]                    rsp_temperature_avg,
   output logic [23:0]                           rsp_status_or,
   output logic [7:0]                            rsp_frames_in_block,
   output logic                                  rsp_no_frames,
   output logic [31:0]                           rsp_valid_total,
   output logic [31:0]                           rsp_crc_error_total,
   output logic [31:0]                           rsp_sync_error_total,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sfpa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [7:0]                            csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_STEP   = 3'd1;
   localparam logic [2:0] ST_CRC    = 3'd2;
   localparam logic [2:0] ST_PSTART = 3'd3;
   localparam logic [2:0] ST_PWAIT  = 3'd4;
   localparam logic [2:0] ST_TSTART = 3'd5;
   localparam logic [2:0] ST_TWAIT  = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]                          state_ff;
   logic [2:0]                          state_in;

   logic [sfpa_pkg::BYTE_W-1:0]         start_ff;
   logic [sfpa_pkg::BYTE_W-1:0]         full_count_ff;
   logic [sfpa_pkg::SHIFT_W-1:0]        full_shift_ff;

   logic [sfpa_pkg::BYTE_W-1:0]         byte_ff;
   logic                                end_ff;
   logic [sfpa_pkg::POS_W-1:0]          pos_ff;
   logic [sfpa_pkg::BYTE_W-1:0]         frame_ff [1:11];

   logic [sfpa_pkg::SUM_W-1:0]          psum_ff;
   logic [sfpa_pkg::SUM_W-1:0]          tsum_ff;
   logic [sfpa_pkg::STATUS_W-1:0]       status_ff;
   logic [sfpa_pkg::BYTE_W-1:0]         count_ff;
   logic [sfpa_pkg::TOTAL_W-1:0]        good_total_ff;
   logic [sfpa_pkg::TOTAL_W-1:0]        crc_total_ff;
   logic [sfpa_pkg::TOTAL_W-1:0]        sync_total_ff;

   logic [sfpa_pkg::SUM_W-1:0]          pavg_ff;
   logic [sfpa_pkg::SUM_W-1:0]          tavg_ff;

   logic                                rsp_valid_ff;
   logic [sfpa_pkg::PRESS_W-1:0]        rsp_press_ff;
   logic [sfpa_pkg::TEMP_W-1:0]         rsp_temp_ff;
   logic [sfpa_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [sfpa_pkg::BYTE_W-1:0]         rsp_count_ff;
   logic                                rsp_none_ff;
   logic [sfpa_pkg::TOTAL_W-1:0]        rsp_good_ff;
   logic [sfpa_pkg::TOTAL_W-1:0]        rsp_crc_ff;
   logic [sfpa_pkg::TOTAL_W-1:0]        rsp_sync_ff;

   sfpa_pkg::crc_cmd_type               crc_cmd;
   sfpa_pkg::div_cmd_type               div_cmd;
   logic [15:0]                         crc_value;
   logic                                crc_busy;
   logic                                div_done;
   logic [sfpa_pkg::SUM_W-1:0]          div_quot;

   logic                                req_fire;
   logic                                is_start;
   logic                                crc_match;
   logic                                count_zero;
   logic                                count_full;
   logic                                out_free;
   logic [sfpa_pkg::SUM_W-1:0]          p_ext;
   logic [sfpa_pkg::SUM_W-1:0]          t_ext;
   logic [sfpa_pkg::SUM_W-1:0]          p_shift;
   logic [sfpa_pkg::SUM_W-1:0]          t_shift;
   logic [sfpa_pkg::SUM_W-1:0]          p_direct;
   logic [sfpa_pkg::SUM_W-1:0]          t_direct;
   logic [sfpa_pkg::SUM_W-1:0]          div_clamped;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign is_start   = (byte_ff == start_ff);
   assign crc_match  = ({byte_ff, frame_ff[11]} == crc_value);
   assign count_zero = (count_ff == 8'd0);
   assign count_full = (count_ff == full_count_ff);

   assign p_ext = {{8{frame_ff[3][7]}}, frame_ff[3], frame_ff[2], frame_ff[1]};
   assign t_ext = {{16{frame_ff[5][7]}}, frame_ff[5], frame_ff[4]};

   assign p_shift  = 32'($signed(psum_ff) >>> full_shift_ff);
   assign t_shift  = 32'($signed(tsum_ff) >>> full_shift_ff);
   assign p_direct = sfpa_pkg::clamp_mag(p_shift[31], sfpa_pkg::magnitude(p_shift),
                                         sfpa_pkg::PRESS_MAX);
   assign t_direct = sfpa_pkg::clamp_mag(t_shift[31], sfpa_pkg::magnitude(t_shift),
                                         sfpa_pkg::TEMP_MAX);
   // quotient sign follows the sum being divided
   assign div_clamped = (state_ff == ST_PWAIT) ?
                        sfpa_pkg::clamp_mag(psum_ff[31], div_quot, sfpa_pkg::PRESS_MAX) :
                        sfpa_pkg::clamp_mag(tsum_ff[31], div_quot, sfpa_pkg::TEMP_MAX);

   always_comb begin
      crc_cmd.start = 1'b0;
      crc_cmd.clear = 1'b0;
      crc_cmd.data  = byte_ff;
      if (state_ff == ST_STEP) begin
         if (pos_ff == sfpa_pkg::POS_HUNT) begin
            crc_cmd.start = is_start;
         end else if (pos_ff >= sfpa_pkg::POS_CRC_HI) begin
            crc_cmd.clear = 1'b1;
         end else begin
            crc_cmd.start = (pos_ff <= sfpa_pkg::POS_CRC_LAST);
         end
      end
   end

   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.dividend = sfpa_pkg::magnitude(psum_ff);
      div_cmd.divisor  = count_ff;
      if (state_ff == ST_PSTART) begin
         div_cmd.start = !count_zero && !count_full;
      end else if (state_ff == ST_TSTART) begin
         div_cmd.start    = !count_zero && !count_full;
         div_cmd.dividend = sfpa_pkg::magnitude(tsum_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (crc_cmd.start) state_in = ST_CRC;
            else if (end_ff)   state_in = ST_PSTART;
            else               state_in = ST_IDLE;
         end
         ST_CRC: begin
            if (!crc_busy) state_in = end_ff ? ST_PSTART : ST_IDLE;
         end
         ST_PSTART: begin
            state_in = div_cmd.start ? ST_PWAIT : ST_TSTART;
         end
         ST_PWAIT: begin
            if (div_done) state_in = ST_TSTART;
         end
         ST_TSTART: begin
            state_in = div_cmd.start ? ST_TWAIT : ST_OUT;
         end
         ST_TWAIT: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= sfpa_pkg::START_RESET;
         full_count_ff <= sfpa_pkg::FULL_RESET;
         full_shift_ff <= sfpa_pkg::SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sfpa_pkg::CSR_START_BYTE: start_ff      <= csr_data;
            sfpa_pkg::CSR_FULL_COUNT: full_count_ff <= csr_data;
            sfpa_pkg::CSR_FULL_SHIFT: full_shift_ff <= csr_data[sfpa_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_rx_byte;
         end_ff  <= req_block_end;
      end
      if (state_ff == ST_STEP && pos_ff != sfpa_pkg::POS_HUNT
          && pos_ff <= sfpa_pkg::POS_CRC_LO) begin
         frame_ff[pos_ff] <= byte_ff;
      end
      if (state_ff == ST_PSTART) begin
         pavg_ff <= count_zero ? '0 : p_direct;
      end
      if (state_ff == ST_PWAIT && div_done) begin
         pavg_ff <= div_clamped;
      end
      if (state_ff == ST_TSTART) begin
         tavg_ff <= count_zero ? '0 : t_direct;
      end
      if (state_ff == ST_TWAIT && div_done) begin
         tavg_ff <= div_clamped;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_press_ff  <= pavg_ff[sfpa_pkg::PRESS_W-1:0];
         rsp_temp_ff   <= tavg_ff[sfpa_pkg::TEMP_W-1:0];
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         rsp_none_ff   <= count_zero;
         rsp_good_ff   <= good_total_ff;
         rsp_crc_ff    <= crc_total_ff;
         rsp_sync_ff   <= sync_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= sfpa_pkg::POS_HUNT;
         psum_ff       <= '0;
         tsum_ff       <= '0;
         status_ff     <= '0;
         count_ff      <= '0;
         good_total_ff <= '0;
         crc_total_ff  <= '0;
         sync_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_STEP) begin
            if (pos_ff == sfpa_pkg::POS_HUNT) begin
               if (is_start) pos_ff <= 4'd1;
               else          sync_total_ff <= sync_total_ff + 32'd1;
            end else if (pos_ff >= sfpa_pkg::POS_CRC_HI) begin
               pos_ff <= sfpa_pkg::POS_HUNT;
               if (crc_match) begin
                  psum_ff       <= psum_ff + p_ext;
                  tsum_ff       <= tsum_ff + t_ext;
                  status_ff     <= status_ff | {frame_ff[10], frame_ff[9], frame_ff[8]};
                  good_total_ff <= good_total_ff + 32'd1;
                  if (count_ff != 8'd255) count_ff <= count_ff + 8'd1;
               end else begin
                  crc_total_ff <= crc_total_ff + 32'd1;
               end
            end else begin
               pos_ff <= pos_ff + 4'd1;
            end
         end
         // hand the result over and clear the block
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            psum_ff      <= '0;
            tsum_ff      <= '0;
            status_ff    <= '0;
            count_ff     <= '0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   sfpa_crc_serial u_crc (
      .clock     (clock),
      .reset     (reset),
      .cmd       (crc_cmd),
      .crc_value (crc_value),
      .busy      (crc_busy)
   );

   sfpa_div_serial u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pressure_avg     = rsp_press_ff;
   assign rsp_temperature_avg  = rsp_temp_ff;
   assign rsp_status_or        = rsp_status_ff;
   assign rsp_frames_in_block  = rsp_count_ff;
   assign rsp_no_frames        = rsp_none_ff;
   assign rsp_valid_total      = rsp_good_ff;
   assign rsp_crc_error_total  = rsp_crc_ff;
   assign rsp_sync_error_total = rsp_sync_ff;

endmodule

// ===== design/sfpa_crc_serial.sv =====
// ----------------------------------------------------------------------------
// sfpa_crc_serial
// Bit-serial CRC-16 (poly 0x8005, MSB first), one data bit per cycle.
// ----------------------------------------------------------------------------
module sfpa_crc_serial (
   input  logic                          clock,
   input  logic                          reset,
   input  sfpa_pkg::crc_cmd_type         cmd,
   output logic [15:0]                   crc_value,
   output logic                          busy
);

   logic [15:0]                     crc_ff;
   logic [15:0]                     crc_in;
   logic [sfpa_pkg::BYTE_W-1:0]     data_ff;
   logic [sfpa_pkg::CRC_CNT_W-1:0]  cnt_ff;
   logic                            busy_ff;
   logic                            feedback;

   assign feedback = crc_ff[15] ^ data_ff[sfpa_pkg::BYTE_W-1];
   assign crc_in   = {crc_ff[14:0], 1'b0} ^ (feedback ? sfpa_pkg::CRC_POLY : 16'h0000);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= sfpa_pkg::CRC_INIT;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.clear) begin
         crc_ff  <= sfpa_pkg::CRC_INIT;
         busy_ff <= 1'b0;
      end else if (cmd.start) begin
         data_ff <= cmd.data;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         crc_ff  <= crc_in;
         data_ff <= {data_ff[sfpa_pkg::BYTE_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign crc_value = crc_ff;
   assign busy      = busy_ff;

endmodule

// ===== design/sfpa_div_serial.sv =====
// ----------------------------------------------------------------------------
// sfpa_div_serial
// Restoring divider, 32-bit magnitude by 8-bit count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module sfpa_div_serial (
   input  logic                          clock,
   input  logic                          reset,
   input  sfpa_pkg::div_cmd_type         cmd,
   output logic                          done,
   output logic [sfpa_pkg::SUM_W-1:0]    quotient
);

   logic [sfpa_pkg::SUM_W-1:0]      quot_ff;
   logic [sfpa_pkg::BYTE_W-1:0]     rem_ff;
   logic [sfpa_pkg::BYTE_W-1:0]     rem_in;
   logic [sfpa_pkg::BYTE_W-1:0]     divisor_ff;
   logic [sfpa_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [sfpa_pkg::BYTE_W:0]       trial;
   logic                            fits;

   assign trial  = {rem_ff, quot_ff[sfpa_pkg::SUM_W-1]};
   assign fits   = trial >= {1'b0, divisor_ff};
   assign rem_in = fits ? 8'(trial - {1'b0, divisor_ff}) : trial[sfpa_pkg::BYTE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            quot_ff    <= cmd.dividend;
            divisor_ff <= cmd.divisor;
            rem_ff     <= '0;
            cnt_ff     <= '0;
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[sfpa_pkg::SUM_W-2:0], fits};
            cnt_ff  <= cnt_ff + 5'd1;
            if (cnt_ff == sfpa_pkg::DIV_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the sensor frame parser and block averager. A short
// table of hand-built frames and stray bytes runs first under the reset
// settings, then random frame traffic with noise, corrupted CRCs and cut-off
// frames runs under six register settings. Every block report is checked
// field by field against typed-in values for pinned table rows, else a
// predictor tracking the parser, the CRC, the block sums and running totals.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 120;
   localparam int unsigned PHASES        = 6;
   localparam int unsigned LONG_FRAMES   = 24;
   localparam logic [3:0]  NO_END        = 4'hF;
   localparam logic [3:0]  LAST_BYTE     = 4'd12;

   localparam logic [7:0] PHASE_START [PHASES] = '{8'h00, 8'hFF, 8'hA5, 8'h35, 8'h5A, 8'h35};
   localparam logic [7:0] PHASE_FULL  [PHASES] = '{8'd1, 8'd2, 8'd0, 8'd8, 8'd3, 8'd255};
   localparam logic [2:0] PHASE_SHIFT [PHASES] = '{3'd0, 3'd0, 3'd5, 3'd3, 3'd1, 3'd7};
   localparam int         PHASE_SEND  [PHASES] = '{24, 24, 66, 66, 0, 0};
   localparam int         PHASE_RECV  [PHASES] = '{66, 66, 24, 24, 0, 0};

   typedef struct packed {
      logic signed [23:0] press_avg;
      logic signed [15:0] temp_avg;
      logic [23:0]        status;
      logic [7:0]         frames;
      logic               no_frames;
      logic [31:0]        good_total;
      logic [31:0]        crc_total;
      logic [31:0]        sync_total;
   } block_report_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_GOOD, ROW_BAD} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [7:0]       value;
      logic [23:0]      press;
      logic [15:0]      temp;
      logic [23:0]      status;
      logic [7:0]       reps;
      logic [3:0]       end_at;
      logic             pinned;
      block_report_type want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        req_block_end = 1'b0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_pressure_avg;
   logic signed [15:0] rsp_temperature_avg;
   logic [23:0]        rsp_status_or;
   logic [7:0]         rsp_frames_in_block;
   logic               rsp_no_frames;
   logic [31:0]        rsp_valid_total;
   logic [31:0]        rsp_crc_error_total;
   logic [31:0]        rsp_sync_error_total;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [sfpa_pkg::CSR_IDX_W-1:0] csr_index = sfpa_pkg::CSR_START_BYTE;
   logic [7:0]                     csr_data = '0;

   // predictor state
   logic [7:0]  cfg_start_byte = sfpa_pkg::START_RESET;
   logic [7:0]  cfg_full_count = sfpa_pkg::FULL_RESET;
   logic [2:0]  cfg_full_shift = sfpa_pkg::SHIFT_RESET;
   logic [3:0]  frame_pos = sfpa_pkg::POS_HUNT;
   logic [15:0] frame_crc = sfpa_pkg::CRC_INIT;
   logic [7:0]  frame_buf [0:11];
   logic [31:0] press_sum = '0;
   logic [31:0] temp_sum = '0;
   logic [23:0] status_acc = '0;
   logic [7:0]  block_frames = '0;
   logic [31:0] good_frames = '0;
   logic [31:0] crc_fails = '0;
   logic [31:0] hunt_drops = '0;

   block_report_type pending_reports [$];
   script_row_type   script [$];
   logic             pin_on = 1'b0;
   block_report_type pin_report = '0;

   int send_idle_pct = 24;
   int recv_idle_pct = 66;
   int unsigned sent_bytes = 0;
   int unsigned reports_expected = 0;
   int unsigned reports_seen = 0;
   int unsigned settings_written = 0;
   int unsigned fault_count = 0;

   sensor_frame_parser_averager_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .req_block_end        (req_block_end),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pressure_avg     (rsp_pressure_avg),
      .rsp_temperature_avg  (rsp_temperature_avg),
      .rsp_status_or        (rsp_status_or),
      .rsp_frames_in_block  (rsp_frames_in_block),
      .rsp_no_frames        (rsp_no_frames),
      .rsp_valid_total      (rsp_valid_total),
      .rsp_crc_error_total  (rsp_crc_error_total),
      .rsp_sync_error_total (rsp_sync_error_total),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      int k;
      c = crc ^ {b, 8'h00};
      for (k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ sfpa_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // full block: arithmetic shift; otherwise divide, truncating toward zero
   function automatic longint block_mean(input logic [31:0] sum, input longint lo,
                                         input longint hi);
      longint s;
      longint n;
      longint r;
      s = $signed(sum);
      n = block_frames;
      if (block_frames == cfg_full_count) begin
         r = s >>> cfg_full_shift;
      end else begin
         r = s / n;
      end
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   // advance the parser by one byte; return 1 when the byte closes a block
   function automatic logic parse_byte(input logic [7:0] b, input logic blk_end,
                                       output block_report_type rep);
      logic [15:0] got;
      longint      pa;
      longint      ta;
      rep = '0;
      if (frame_pos == sfpa_pkg::POS_HUNT) begin
         if (b == cfg_start_byte) begin
            frame_buf[0] = b;
            frame_crc = crc16_step(sfpa_pkg::CRC_INIT, b);
            frame_pos = 4'd1;
         end else begin
            hunt_drops++;
         end
      end else if (frame_pos >= sfpa_pkg::POS_CRC_HI) begin
         got = {b, frame_buf[11]};
         if (got == frame_crc) begin
            press_sum += {{8{frame_buf[3][7]}}, frame_buf[3], frame_buf[2], frame_buf[1]};
            temp_sum += {{16{frame_buf[5][7]}}, frame_buf[5], frame_buf[4]};
            status_acc |= {frame_buf[10], frame_buf[9], frame_buf[8]};
            if (block_frames != 8'd255) block_frames++;
            good_frames++;
         end else begin
            crc_fails++;
         end
         frame_pos = sfpa_pkg::POS_HUNT;
         frame_crc = sfpa_pkg::CRC_INIT;
      end else begin
         frame_buf[frame_pos] = b;
         if (frame_pos < sfpa_pkg::POS_CRC_LO) frame_crc = crc16_step(frame_crc, b);
         frame_pos++;
      end

      if (!blk_end) return 1'b0;

      if (block_frames == 8'd0) begin
         rep.no_frames = 1'b1;
      end else begin
         pa = block_mean(press_sum, -64'sd8388608, 64'sd8388607);
         ta = block_mean(temp_sum, -64'sd32768, 64'sd32767);
         rep.press_avg = pa[23:0];
         rep.temp_avg = ta[15:0];
      end
      rep.status = status_acc;
      rep.frames = block_frames;
      rep.good_total = good_frames;
      rep.crc_total = crc_fails;
      rep.sync_total = hunt_drops;
      press_sum = '0;
      temp_sum = '0;
      status_acc = '0;
      block_frames = '0;
      return 1'b1;
   endfunction

   task automatic check_field(input string label, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= 10)
            $display("Mismatch in report %0d, %s: expected 0x%0h, got 0x%0h",
                     reports_seen, label, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      block_report_type rep;
      block_report_type want;
      if (reset) begin
         cfg_start_byte = sfpa_pkg::START_RESET;
         cfg_full_count = sfpa_pkg::FULL_RESET;
         cfg_full_shift = sfpa_pkg::SHIFT_RESET;
         frame_pos = sfpa_pkg::POS_HUNT;
         frame_crc = sfpa_pkg::CRC_INIT;
         press_sum = '0;
         temp_sum = '0;
         status_acc = '0;
         block_frames = '0;
         good_frames = '0;
         crc_fails = '0;
         hunt_drops = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sfpa_pkg::CSR_START_BYTE: cfg_start_byte = csr_data;
               sfpa_pkg::CSR_FULL_COUNT: cfg_full_count = csr_data;
               sfpa_pkg::CSR_FULL_SHIFT: cfg_full_shift = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_rx_byte, req_block_end, rep)) begin
               pending_reports.push_back(pin_on ? pin_report : rep);
               reports_expected++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("Unexpected block report: frames %0d, totals %0d/%0d/%0d",
                           rsp_frames_in_block, rsp_valid_total, rsp_crc_error_total,
                           rsp_sync_error_total);
            end else begin
               want = pending_reports.pop_front();
               reports_seen++;
               check_field("pressure_avg", rsp_pressure_avg, want.press_avg);
               check_field("temperature_avg", rsp_temperature_avg, want.temp_avg);
               check_field("status_or", rsp_status_or, want.status);
               check_field("frames_in_block", rsp_frames_in_block, want.frames);
               check_field("no_frames", rsp_no_frames, want.no_frames);
               check_field("valid_total", rsp_valid_total, want.good_total);
               check_field("crc_error_total", rsp_crc_error_total, want.crc_total);
               check_field("sync_error_total", rsp_sync_error_total, want.sync_total);
            end
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_byte(input logic [7:0] b, input logic blk_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_block_end <= blk_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] lead, input logic [23:0] press,
                             input logic [15:0] temp, input logic [23:0] status,
                             input logic [7:0] filler, input logic [15:0] crc_flip,
                             input logic [3:0] end_at);
      logic [7:0]  fb [0:12];
      logic [15:0] c;
      int i;
      fb[0] = lead;
      {fb[3], fb[2], fb[1]} = press;
      {fb[5], fb[4]} = temp;
      fb[6] = filler;
      fb[7] = ~filler;
      {fb[10], fb[9], fb[8]} = status;
      c = sfpa_pkg::CRC_INIT;
      for (i = 0; i < 11; i++) c = crc16_step(c, fb[i]);
      c ^= crc_flip;
      {fb[12], fb[11]} = c;
      for (i = 0; i < 13; i++) push_byte(fb[i], i == end_at);
   endtask

   // hold the sender until every report is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_settings(input logic [7:0] start_val, input logic [7:0] full_val,
                                 input logic [2:0] shift_val);
      logic [sfpa_pkg::CSR_IDX_W-1:0] idx [3];
      logic [7:0]                     val [3];
      int r;
      idx = '{sfpa_pkg::CSR_START_BYTE, sfpa_pkg::CSR_FULL_COUNT, sfpa_pkg::CSR_FULL_SHIFT};
      val = '{start_val, full_val, {5'd0, shift_val}};
      for (r = 0; r < 3; r++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[r];
         csr_data <= val[r];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   function automatic logic [23:0] edgy_value(input int bits);
      logic [23:0] mask;
      mask = (24'd1 << bits) - 24'd1;
      case ($urandom_range(5))
         0: return mask >> 1;
         1: return (mask >> 1) + 24'd1;
         2: return '0;
         3: return mask;
         default: return 24'($urandom) & mask;
      endcase
   endfunction

   function automatic script_row_type make_row(input row_kind_type kind,
                                               input logic [7:0] value,
                                               input logic [23:0] press,
                                               input logic [15:0] temp,
                                               input logic [23:0] status,
                                               input logic [7:0] reps,
                                               input logic [3:0] end_at,
                                               input logic pinned,
                                               input block_report_type want);
      script_row_type row;
      row.kind = kind;
      row.value = value;
      row.press = press;
      row.temp = temp;
      row.status = status;
      row.reps = reps;
      row.end_at = end_at;
      row.pinned = pinned;
      row.want = want;
      return row;
   endfunction

   function automatic block_report_type make_report(input logic [23:0] pa,
                                                    input logic [15:0] ta,
                                                    input logic [23:0] st,
                                                    input logic [7:0] n,
                                                    input logic nf,
                                                    input logic [31:0] good,
                                                    input logic [31:0] bad,
                                                    input logic [31:0] sync);
      block_report_type rep;
      rep.press_avg = pa;
      rep.temp_avg = ta;
      rep.status = st;
      rep.frames = n;
      rep.no_frames = nf;
      rep.good_total = good;
      rep.crc_total = bad;
      rep.sync_total = sync;
      return rep;
   endfunction

   // mostly well-formed frames with random content, some noise and broken frames
   task automatic random_traffic(input logic [7:0] lead, input int unsigned byte_goal,
                                 input int unsigned report_goal);
      int unsigned first_byte;
      int unsigned first_report;
      int pick;
      int n;
      int r;
      logic [3:0] end_at;
      first_byte = sent_bytes;
      first_report = reports_expected;
      while (sent_bytes - first_byte < byte_goal
             || reports_expected - first_report < report_goal) begin
         pick = $urandom_range(99);
         r = $urandom_range(99);
         end_at = (r < 20) ? LAST_BYTE : (r < 26) ? 4'($urandom_range(11)) : NO_END;
         if (pick < 82) begin
            send_frame(lead, edgy_value(24), 16'(edgy_value(16)),
                       ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom), 8'($urandom),
                       (pick < 70) ? 16'd0 : 16'($urandom_range(65535, 1)), end_at);
         end else if (pick < 92) begin
            n = $urandom_range(4, 1);
            repeat (n) push_byte(8'($urandom), $urandom_range(5) == 0);
         end else begin
            // cut the frame short so that it swallows the head of the next one
            push_byte(lead, 1'b0);
            n = $urandom_range(11, 1);
            repeat (n) push_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   initial begin : stimulus
      script_row_type row;
      int unsigned r;
      int k;
      int p;

      // expected values typed in only where they can be read off directly
      script.push_back(make_row(ROW_BYTE, 8'h00, '0, '0, '0, 8'd1, 4'd0, 1'b1,
                                make_report('0, '0, '0, 8'd0, 1'b1, 0, 0, 1)));
      script.push_back(make_row(ROW_BYTE, 8'hFF, '0, '0, '0, 8'd1, 4'd0, 1'b1,
                                make_report('0, '0, '0, 8'd0, 1'b1, 0, 0, 2)));
      script.push_back(make_row(ROW_BAD, 8'hC3, 24'h123456, 16'h789A, 24'h0F0F0F, 8'd1,
                                LAST_BYTE, 1'b1,
                                make_report('0, '0, '0, 8'd0, 1'b1, 0, 1, 2)));
      script.push_back(make_row(ROW_GOOD, 8'hFF, 24'h7FFFFF, 16'h7FFF, 24'hFFFFFF, 8'd1,
                                LAST_BYTE, 1'b1,
                                make_report(24'h7FFFFF, 16'h7FFF, 24'hFFFFFF, 8'd1, 1'b0,
                                            1, 1, 2)));
      script.push_back(make_row(ROW_GOOD, 8'h00, 24'h800000, 16'h8000, 24'h000000, 8'd1,
                                LAST_BYTE, 1'b1,
                                make_report(24'h800000, 16'h8000, 24'h000000, 8'd1, 1'b0,
                                            2, 1, 2)));
      // start byte value inside the frame body
      script.push_back(make_row(ROW_GOOD, 8'h35, 24'h353535, 16'h3535, 24'h353535, 8'd1,
                                NO_END, 1'b0, '0));
      // block ends mid-frame; the frame completes in the next block
      script.push_back(make_row(ROW_GOOD, 8'h5A, 24'h000100, 16'h0002, 24'h000000, 8'd1,
                                4'd5, 1'b1,
                                make_report(24'h353535, 16'h3535, 24'h353535, 8'd1, 1'b0,
                                            3, 1, 2)));
      // fill the block to the full count with negative readings
      script.push_back(make_row(ROW_GOOD, 8'h96, 24'hFFFFFD, 16'hFFFF, 24'h010204, 8'd7,
                                LAST_BYTE, 1'b0, '0));
      // stray start byte throws the next frame out of step
      script.push_back(make_row(ROW_BYTE, 8'h35, '0, '0, '0, 8'd1, NO_END, 1'b0, '0));
      script.push_back(make_row(ROW_GOOD, 8'h11, 24'h000001, 16'h0001, 24'h800000, 8'd1,
                                LAST_BYTE, 1'b0, '0));
      script.push_back(make_row(ROW_BYTE, 8'h00, '0, '0, '0, 8'd1, 4'd0, 1'b0, '0));
      script.push_back(make_row(ROW_GOOD, 8'h77, 24'hABCDEF, 16'h1234, 24'h00FF00, 8'd1,
                                4'd0, 1'b0, '0));
      script.push_back(make_row(ROW_BYTE, 8'hFF, '0, '0, '0, 8'd1, 4'd0, 1'b0, '0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 24;
      recv_idle_pct = 66;
      for (r = 0; r < script.size(); r++) begin
         row = script[r];
         pin_on = row.pinned;
         pin_report = row.want;
         if (row.kind == ROW_BYTE) begin
            push_byte(row.value, row.end_at == 4'd0);
         end else begin
            for (k = 0; k < row.reps; k++)
               send_frame(sfpa_pkg::START_RESET, row.press, row.temp, row.status, row.value,
                          (row.kind == ROW_BAD) ? 16'h0001 : 16'h0000,
                          (k == row.reps - 1) ? row.end_at : NO_END);
         end
         pin_on = 1'b0;
      end
      settle();

      for (p = 0; p < PHASES; p++) begin
         write_settings(PHASE_START[p], PHASE_FULL[p], PHASE_SHIFT[p]);
         send_idle_pct = PHASE_SEND[p];
         recv_idle_pct = PHASE_RECV[p];
         if (p == PHASES - 1) begin
            // one long block of extreme readings under the largest full count
            for (k = 0; k < LONG_FRAMES; k++)
               send_frame(PHASE_START[p], 24'h7FFFFF, 16'h7FFF, 24'($urandom), 8'($urandom),
                          16'h0000, (k == LONG_FRAMES - 1) ? LAST_BYTE : NO_END);
         end
         random_traffic(PHASE_START[p], 130, 3);
         settle();
      end

      if (pending_reports.size() != 0) begin
         fault_count += pending_reports.size();
         $display("%0d block reports never arrived", pending_reports.size());
      end
      $display("Sent %0d bytes under the reset settings and %0d written settings;",
               sent_bytes, settings_written);
      $display("checked %0d block reports over %0d good, %0d CRC-failed frames,",
               reports_seen, good_frames, crc_fails);
      $display("and %0d bytes dropped while hunting.", hunt_drops);
      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d block reports outstanding", pending_reports.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sfpa_pkg.sv
design/sfpa_crc_serial.sv
design/sfpa_div_serial.sv
design/sensor_frame_parser_averager_core.sv
tb/tb_top.sv
